// ===== rtl/gcs_pkg.sv =====
// Package for the greedy capacity splitter: sizes, codes and payload types.
package gcs_pkg;

    localparam int RECEIVERS   = 32;
    localparam int AMOUNT_BITS = 24;

    localparam int IDX_W  = (RECEIVERS > 1) ? $clog2(RECEIVERS) : 1;
    localparam int ACT_W  = 6;
    localparam int VIS_W  = ACT_W + 1;
    localparam int SLOT_W = 5;
    localparam int TAG_W  = 16;
    localparam int ADDR_W = 2;
    localparam int DATA_W = 32;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(32);

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    localparam logic [ADDR_W-1:0] ADDR_ACTIVE = '0;

    typedef struct packed {
        logic                   mode;
        logic [SLOT_W-1:0]      receiver_slot;
        logic [AMOUNT_BITS-1:0] load_capacity;
        logic [TAG_W-1:0]       object_id;
        logic [AMOUNT_BITS-1:0] demand;
        logic                   batch_last;
    } t_in;

    typedef struct packed {
        logic [TAG_W-1:0]       object_tag;
        logic [SLOT_W-1:0]      target_receiver;
        logic [AMOUNT_BITS-1:0] share;
        logic [AMOUNT_BITS-1:0] demand_left;
        logic                   run_end;
        logic                   batch_end;
    } t_out;

    typedef struct packed {
        logic                   we;
        logic [IDX_W-1:0]       waddr;
        logic [AMOUNT_BITS-1:0] wdata;
        logic                   re;
        logic [IDX_W-1:0]       raddr;
    } t_cap_req;

endpackage

// ===== rtl/gcs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module gcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gcs_cap_store.sv =====
// Remaining-capacity table: RAM plus per-entry valid bits so unwritten entries read as zero.
module gcs_cap_store (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gcs_pkg::t_cap_req                i_req,
    output logic [gcs_pkg::AMOUNT_BITS-1:0]  o_cap
);
    import gcs_pkg::*;

    logic [RECEIVERS-1:0]   r_vld;
    logic                   r_rd_vld;
    logic [AMOUNT_BITS-1:0] ram_q;

    gcs_ram #(
        .WIDTH (AMOUNT_BITS),
        .DEPTH (RECEIVERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.we),
        .i_waddr (i_req.waddr),
        .i_wdata (i_req.wdata),
        .i_re    (i_req.re),
        .i_raddr (i_req.raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            // The flag follows the RAM read so that stalled data keeps its flag.
            if (i_req.re) begin
                r_rd_vld <= r_vld[i_req.raddr];
            end
        end
    end

    assign o_cap = r_rd_vld ? ram_q : '0;

endmodule

// ===== rtl/gcs_apb_regs.sv =====
// APB-style configuration register holding the active receiver count.
module gcs_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gcs_pkg::ADDR_W-1:0]  paddr,
    input  logic [gcs_pkg::DATA_W-1:0]  pwdata,
    output logic [gcs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [gcs_pkg::ACT_W-1:0]   o_active
);
    import gcs_pkg::*;

    logic [ACT_W-1:0] r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (psel && penable && pwrite && pready) begin
            r_active <= pwdata[ACT_W-1:0];
        end
    end

    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_ACTIVE) ? DATA_W'(r_active) : '0;
    assign o_active = r_active;

endmodule

// ===== rtl/greedy_capacity_splitter.sv =====
// Greedy capacity splitter: places object demand onto receivers in index order.
// A load transaction writes one table entry.
// An allocation starts by reading the first entry, then visits one receiver at
// a time (one table read-modify-write each); an output stall holds the walk. The
// first result is registered from the first entry read once the output can take it.
// Synchronous active-low reset clears the table (via valid bits) and sets 32 receivers.
module greedy_capacity_splitter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  gcs_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output gcs_pkg::t_out               o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gcs_pkg::ADDR_W-1:0]  paddr,
    input  logic [gcs_pkg::DATA_W-1:0]  pwdata,
    output logic [gcs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import gcs_pkg::*;

    typedef enum logic {S_IDLE, S_WALK} t_state;

    t_state                 r_state;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       r_last_idx;
    logic [AMOUNT_BITS-1:0] r_left;
    logic [TAG_W-1:0]       r_tag;
    logic                   r_blast;
    logic                   r_out_valid;
    t_out                   r_out;

    logic [ACT_W-1:0]       active;
    logic [VIS_W-1:0]       visits;
    logic [AMOUNT_BITS-1:0] cap;
    logic [AMOUNT_BITS-1:0] share;
    logic [AMOUNT_BITS-1:0] n_left;
    logic                   in_acc;
    logic                   start;
    logic                   load;
    logic                   step;
    logic                   last;
    t_cap_req               cap_req;

    gcs_apb_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_active (active)
    );

    gcs_cap_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cap_req),
        .o_cap   (cap)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    assign visits = ({1'b0, active} > VIS_W'(RECEIVERS)) ? VIS_W'(RECEIVERS)
                                                         : {1'b0, active};

    assign start = in_acc && (i_in_data.mode == MODE_ALLOC)
                   && (i_in_data.demand != '0) && (visits != '0);
    assign load  = in_acc && (i_in_data.mode == MODE_LOAD)
                   && (32'(i_in_data.receiver_slot) < 32'(RECEIVERS));

    assign share  = (cap < r_left) ? cap : r_left;
    assign n_left = r_left - share;
    assign step   = (r_state == S_WALK) && (!r_out_valid || i_out_ready);
    assign last   = (r_idx == r_last_idx) || (n_left == '0);

    // Write-back of entry j and read of entry j+1 share a cycle; they never collide.
    always_comb begin
        cap_req.we    = load || step;
        cap_req.waddr = load ? IDX_W'(i_in_data.receiver_slot) : r_idx;
        cap_req.wdata = load ? i_in_data.load_capacity : (cap - share);
        cap_req.re    = start || (step && !last);
        cap_req.raddr = start ? '0 : (r_idx + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (step && last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (step) begin
                r_out.object_tag      <= r_tag;
                r_out.target_receiver <= SLOT_W'(r_idx);
                r_out.share           <= share;
                r_out.demand_left     <= n_left;
                r_out.run_end         <= last;
                r_out.batch_end       <= r_blast;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_idx      <= '0;
            r_last_idx <= IDX_W'(visits - 1'b1);
            r_left     <= i_in_data.demand;
            r_tag      <= i_in_data.object_id;
            r_blast    <= i_in_data.batch_last;
        end else if (step) begin
            r_idx  <= r_idx + 1'b1;
            r_left <= n_left;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_idx <= r_last_idx))
        else $error("walk index beyond last visited receiver");

    a_share_conserves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> ((AMOUNT_BITS+1)'(o_out_data.share)
                  + (AMOUNT_BITS+1)'(o_out_data.demand_left)
                  == (AMOUNT_BITS+1)'($past(r_left))))
        else $error("share plus remaining demand differs from prior demand");

    a_run_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && last) |=> (r_state == S_IDLE) && o_out_data.run_end)
        else $error("walk did not end with a final result");
`endif

endmodule
